[rtl/dsh_pkg.sv]
package dsh_pkg;

  // grid limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // field and register widths
  localparam int VOLT_W     = 24;
  localparam int COEF_W     = 16;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // arithmetic widths
  localparam int DIFF_W = VOLT_W + 2;
  localparam int PROD_W = COEF_W + 1 + DIFF_W;
  localparam int BASE_W = VOLT_W + COEF_W;
  localparam int ACC_W  = BASE_W + 6;
  localparam int Q_W    = ACC_W - COEF_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_VERTICAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_HORIZONTAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT     = 2'd3;

  // reset values
  localparam logic [COEF_W-1:0] COEF_RESET = 16'd5825;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef logic signed [VOLT_W-1:0] volt_t;

  // registered read data of both row stores
  typedef struct packed {
    volt_t even_a;
    volt_t even_b;
    volt_t odd_a;
    volt_t odd_b;
  } row_rd_t;

  // the five neighbors of one cell plus the end-of-grid mark
  typedef struct packed {
    volt_t ctr;
    volt_t up;
    volt_t dn;
    volt_t lf;
    volt_t rt;
    logic  done;
  } stencil_op_t;

endpackage

[rtl/dsh_if.sv]
interface dsh_feed_if import dsh_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  volt_t voltage_in;

  modport source (output valid, output action, output voltage_in, input ready);
  modport sink (input valid, input action, input voltage_in, output ready);
endinterface

interface dsh_result_if import dsh_pkg::*; ();
  logic  valid;
  logic  ready;
  volt_t voltage_out;
  logic  grid_done;

  modport source (output valid, output voltage_out, output grid_done, input ready);
  modport sink (input valid, input voltage_out, input grid_done, output ready);
endinterface

interface dsh_cfg_if import dsh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/dsh_row_store.sv]
module dsh_row_store import dsh_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr_a,
  input  logic [COL_W-1:0] rd_addr_b,
  input  logic             wr_en,
  input  logic             wr_parity,
  input  logic [COL_W-1:0] wr_addr,
  input  volt_t            wr_data,
  output row_rd_t          rd
);

  volt_t mem_even [MAX_WIDTH];
  volt_t mem_odd  [MAX_WIDTH];

  // read-first: a read at the written address returns the old row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd.even_a <= mem_even[rd_addr_a];
      rd.even_b <= mem_even[rd_addr_b];
      rd.odd_a  <= mem_odd[rd_addr_a];
      rd.odd_b  <= mem_odd[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_parity) begin
      mem_even[wr_addr] <= wr_data;
    end
    if (wr_en && wr_parity) begin
      mem_odd[wr_addr] <= wr_data;
    end
  end

endmodule

[rtl/dsh_stencil_pipe.sv]
module dsh_stencil_pipe import dsh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_ready,
  input  stencil_op_t        op,
  input  logic [COEF_W-1:0]  coef_vertical,
  input  logic [COEF_W-1:0]  coef_horizontal,
  dsh_result_if.source       result
);

  localparam logic [COEF_W-1:0] HALF = COEF_W'(1) << (COEF_W - 1);

  // stage 2: second differences
  logic                     s2_valid;
  volt_t                    s2_ctr;
  logic signed [DIFF_W-1:0] s2_dv;
  logic signed [DIFF_W-1:0] s2_dh;
  logic                     s2_done;

  // stage 3: weighted differences
  logic                     s3_valid;
  logic signed [BASE_W-1:0] s3_base;
  logic signed [PROD_W-1:0] s3_pv;
  logic signed [PROD_W-1:0] s3_ph;
  logic                     s3_done;

  // output register
  logic                     out_valid;
  volt_t                    out_volt;
  logic                     out_done;

  logic                     s3_move;
  logic                     s3_ready;
  logic                     s2_move;
  logic signed [ACC_W-1:0]  acc;
  logic signed [Q_W-1:0]    q;
  logic                     sat;
  volt_t                    rounded;

  assign s3_move  = s3_valid && (!out_valid || result.ready);
  assign s3_ready = !s3_valid || s3_move;
  assign s2_move  = s2_valid && s3_ready;
  assign op_ready = !s2_valid || s2_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (op_ready) begin
      s2_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && op_ready) begin
      s2_ctr  <= op.ctr;
      s2_dv   <= DIFF_W'(op.up) + DIFF_W'(op.dn) - (DIFF_W'(op.ctr) <<< 1);
      s2_dh   <= DIFF_W'(op.lf) + DIFF_W'(op.rt) - (DIFF_W'(op.ctr) <<< 1);
      s2_done <= op.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  // center scaled by 2^16 with the rounding half folded into the low bits
  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_base <= $signed({s2_ctr, HALF});
      s3_pv   <= $signed({1'b0, coef_vertical}) * s2_dv;
      s3_ph   <= $signed({1'b0, coef_horizontal}) * s2_dh;
      s3_done <= s2_done;
    end
  end

  assign acc = ACC_W'(s3_base) + ACC_W'(s3_pv) + ACC_W'(s3_ph);
  assign q   = acc[ACC_W-1:COEF_W];
  assign sat = (q[Q_W-1:VOLT_W-1] != '0) && (q[Q_W-1:VOLT_W-1] != '1);

  always_comb begin
    if (!sat) begin
      rounded = q[VOLT_W-1:0];
    end else if (q[Q_W-1]) begin
      rounded = {1'b1, {(VOLT_W-1){1'b0}}};
    end else begin
      rounded = {1'b0, {(VOLT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_move) begin
      out_volt <= rounded;
      out_done <= s3_done;
    end
  end

  assign result.valid       = out_valid;
  assign result.voltage_out = out_volt;
  assign result.grid_done   = out_done;

endmodule

[rtl/diffusion_stencil_half_step_core.sv]
// path: a cell's result, made once the item below it (or its drain item) is accepted,
//   passes the stage 1, stage 2, stage 3 and output registers
// throughput: one item per cycle while unstalled, set by one row store read and write
// reset: positions and drain flag cleared, coefficients 5825, grid size 1024 x 1024;
//   the row stores are not cleared and hold garbage until written
module diffusion_stencil_half_step_core import dsh_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  dsh_feed_if.sink      feed,
  dsh_result_if.source  result,
  dsh_cfg_if.sink       cfg
);

  localparam int CNT_W  = COL_W + 1;
  localparam int RCNT_W = ROW_W + 1;

  // configuration registers
  logic [COEF_W-1:0] coef_vertical;
  logic [COEF_W-1:0] coef_horizontal;
  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;

  // raster position
  logic [COL_W-1:0]  column_position;
  logic [ROW_W-1:0]  row_position;
  logic              draining;
  volt_t             left_cell;

  logic [CNT_W-1:0]  width_eff;
  logic [RCNT_W-1:0] height_eff;
  logic              last_col;
  logic              last_row;
  logic              rt_is_ctr;
  logic [COL_W-1:0]  rd_addr_b;
  logic              feed_fire;
  logic              take;
  logic              sample;

  // stage 1: row store data arrives, neighbor selects are registered alongside
  logic              s1_valid;
  logic              s1_cp;
  logic              s1_up_is_ctr;
  logic              s1_lf_is_ctr;
  logic              s1_rt_is_ctr;
  logic              s1_dn_is_ctr;
  volt_t             s1_dn;
  logic              s1_done;

  row_rd_t           rd;
  stencil_op_t       op;
  logic              op_ready;

  // config port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vertical   <= COEF_RESET;
      coef_horizontal <= COEF_RESET;
      grid_width      <= SIZE_RESET;
      grid_height     <= SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_COEF_VERTICAL:   coef_vertical   <= cfg.data;
        REG_COEF_HORIZONTAL: coef_horizontal <= cfg.data;
        REG_GRID_WIDTH:      grid_width      <= cfg.data[SIZE_W-1:0];
        REG_GRID_HEIGHT:     grid_height     <= cfg.data[SIZE_W-1:0];
      endcase
    end
  end

  // zero counts as one, anything past the store depth counts as the depth
  always_comb begin
    if (grid_width == '0) begin
      width_eff = CNT_W'(1);
    end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
      width_eff = CNT_W'(MAX_WIDTH);
    end else begin
      width_eff = CNT_W'(grid_width);
    end
  end

  always_comb begin
    if (grid_height == '0) begin
      height_eff = RCNT_W'(1);
    end else if (32'(grid_height) > 32'(MAX_HEIGHT)) begin
      height_eff = RCNT_W'(MAX_HEIGHT);
    end else begin
      height_eff = RCNT_W'(grid_height);
    end
  end

  assign last_col  = (CNT_W'(column_position) + CNT_W'(1)) >= width_eff;
  assign last_row  = (RCNT_W'(row_position) + RCNT_W'(1)) >= height_eff;
  assign rt_is_ctr = last_col || (column_position == COL_W'(MAX_WIDTH - 1));
  assign rd_addr_b = rt_is_ctr ? column_position : column_position + COL_W'(1);

  // an item whose kind does not match the phase is dropped without effect
  assign feed.ready = !s1_valid || op_ready;
  assign feed_fire  = feed.valid && feed.ready;
  assign take       = feed_fire && (feed.action == draining);
  assign sample     = take && !draining;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      draining        <= 1'b0;
    end else if (take) begin
      if (last_col) begin
        column_position <= '0;
        if (draining) begin
          row_position <= '0;
          draining     <= 1'b0;
        end else if (last_row) begin
          draining <= 1'b1;
        end else begin
          row_position <= row_position + ROW_W'(1);
        end
      end else begin
        column_position <= column_position + COL_W'(1);
      end
    end
  end

  // a sample goes into the store of its row's parity, over the row two above;
  // both stores are read at c and c+1 (or c twice at the edge) on each accepted item
  dsh_row_store u_row_store (
    .clk       (clk),
    .rd_en     (feed_fire),
    .rd_addr_a (column_position),
    .rd_addr_b (rd_addr_b),
    .wr_en     (sample),
    .wr_parity (row_position[0]),
    .wr_addr   (column_position),
    .wr_data   (feed.voltage_in),
    .rd        (rd)
  );

  // the first row of samples produces nothing; every drain item produces a result
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (feed.ready) begin
      s1_valid <= take && (draining || (row_position != '0));
    end
  end

  // center row is the previous row for a sample, the current row while draining
  always_ff @(posedge clk) begin
    if (feed_fire) begin
      s1_cp        <= draining ? row_position[0] : ~row_position[0];
      s1_up_is_ctr <= draining ? (row_position == '0)
                               : (RCNT_W'(row_position) < RCNT_W'(2));
      s1_lf_is_ctr <= column_position == '0;
      s1_rt_is_ctr <= rt_is_ctr;
      s1_dn_is_ctr <= draining;
      s1_dn        <= feed.voltage_in;
      s1_done      <= draining && last_col;
    end
  end

  // no-flux edges: a missing neighbor takes the center's value
  always_comb begin
    op.ctr  = s1_cp ? rd.odd_a : rd.even_a;
    op.up   = s1_up_is_ctr ? op.ctr : (s1_cp ? rd.even_a : rd.odd_a);
    op.dn   = s1_dn_is_ctr ? op.ctr : s1_dn;
    op.lf   = s1_lf_is_ctr ? op.ctr : left_cell;
    op.rt   = s1_rt_is_ctr ? op.ctr : (s1_cp ? rd.odd_b : rd.even_b);
    op.done = s1_done;
  end

  // left neighbor of the next cell is this cell's center
  always_ff @(posedge clk) begin
    if (rst) begin
      left_cell <= '0;
    end else if (s1_valid && op_ready) begin
      left_cell <= op.ctr;
    end
  end

  dsh_stencil_pipe u_stencil_pipe (
    .clk             (clk),
    .rst             (rst),
    .op_valid        (s1_valid),
    .op_ready        (op_ready),
    .op              (op),
    .coef_vertical   (coef_vertical),
    .coef_horizontal (coef_horizontal),
    .result          (result)
  );

endmodule
